@@ hdl/lps_pkg.sv @@
package lps_pkg;

	localparam int NUM_PROBES = 8;
	localparam int ERR_W      = 7;
	localparam int SUM_W      = 24;
	localparam int GAIN_W     = 8;
	localparam int STEER_W    = 32;
	localparam int CFG_IDX_W  = 2;

	typedef logic        [7:0]         probe_t;
	typedef logic signed [ERR_W-1:0]   err_t;
	typedef logic signed [ERR_W:0]     diff_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic        [GAIN_W-1:0]  gain_t;
	typedef logic signed [STEER_W-1:0] steer_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P = 2'd0,
		REG_GAIN_I = 2'd1,
		REG_GAIN_D = 2'd2
	} reg_idx_t;

	typedef struct packed {
		gain_t p;
		gain_t i;
		gain_t d;
	} gains_t;

	localparam gain_t GAIN_P_RST = 8'd120;
	localparam gain_t GAIN_I_RST = 8'd0;
	localparam gain_t GAIN_D_RST = 8'd8;

	localparam sum_t SUM_MAX = 24'sh7FFFFF;
	localparam sum_t SUM_MIN = 24'sh800000;

	localparam err_t PROBE_WEIGHT [NUM_PROBES] = '{
		-7'sd20, -7'sd15, -7'sd10, -7'sd5, 7'sd5, 7'sd10, 7'sd15, 7'sd20
	};

endpackage

@@ hdl/lps_if.sv @@
interface lps_probe_if;
	import lps_pkg::*;
	logic   valid;
	logic   ready;
	probe_t probe_bits;
	modport source (output valid, output probe_bits, input ready);
	modport sink   (input valid, input probe_bits, output ready);
endinterface

interface lps_result_if;
	import lps_pkg::*;
	logic   valid;
	logic   ready;
	steer_t steer;
	err_t   line_error;
	logic   turn_latched;
	modport source (output valid, output steer, output line_error, output turn_latched,
		input ready);
	modport sink   (input valid, input steer, input line_error, input turn_latched,
		output ready);
endinterface

interface lps_cfg_if;
	import lps_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	gain_t                data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/lps_lane.sv @@
module lps_lane (
	input  logic          probe,
	input  lps_pkg::err_t weight,
	output lps_pkg::err_t contrib
);
	import lps_pkg::*;

	// black probe (0) contributes its weight
	assign contrib = probe ? '0 : weight;
endmodule

@@ hdl/lps_error.sv @@
module lps_error (
	input  lps_pkg::probe_t probe_bits,
	output lps_pkg::err_t   line_error
);
	import lps_pkg::*;

	err_t contrib [NUM_PROBES];
	err_t lvl1    [NUM_PROBES/2];
	err_t lvl2    [NUM_PROBES/4];

	for (genvar g = 0; g < NUM_PROBES; g++) begin : g_lane
		lps_lane u_lane (
			.probe   (probe_bits[g]),
			.weight  (PROBE_WEIGHT[g]),
			.contrib (contrib[g])
		);
	end

	// merge tree, every partial sum stays within -50..50
	always_comb begin
		for (int k = 0; k < NUM_PROBES/2; k++) begin
			lvl1[k] = contrib[2*k] + contrib[2*k+1];
		end
		for (int k = 0; k < NUM_PROBES/4; k++) begin
			lvl2[k] = lvl1[2*k] + lvl1[2*k+1];
		end
		line_error = lvl2[0] + lvl2[1];
	end
endmodule

@@ hdl/lps_pid.sv @@
module lps_pid (
	input  logic            clk,
	input  logic            arst_n,
	input  lps_pkg::gains_t gains,
	input  logic            in_valid,
	output logic            in_ready,
	input  lps_pkg::err_t   in_error,
	input  logic            in_turn_hit,
	output logic            out_valid,
	input  logic            out_ready,
	output lps_pkg::steer_t out_steer,
	output lps_pkg::err_t   out_error,
	output logic            out_turn
);
	import lps_pkg::*;

	logic  v_s1, v_s2, v_s3, v_q;
	logic  r_s1, r_s2, r_s3, r_q;
	err_t  err_s1, err_s2, err_s3;
	logic  hit_s1;
	logic  turn_s2, turn_s3;
	sum_t  sum_s2;
	diff_t diff_s2;

	logic signed [15:0] p_prod_s3;
	logic signed [32:0] i_prod_s3;
	logic signed [16:0] d_prod_s3;

	err_t  prev_err_q;
	sum_t  err_sum_q;
	logic  turn_seen_q;

	logic signed [SUM_W:0]     sum_wide;
	sum_t                      sum_next;
	diff_t                     diff_next;
	logic                      turn_next;
	logic signed [STEER_W+1:0] total;
	steer_t                    steer_sat;

	assign r_q  = !v_q  || out_ready;
	assign r_s3 = !v_s3 || r_q;
	assign r_s2 = !v_s2 || r_s3;
	assign r_s1 = !v_s1 || r_s2;
	assign in_ready = r_s1;

	always_comb begin
		sum_wide  = {err_sum_q[SUM_W-1], err_sum_q} + {{(SUM_W-ERR_W+1){err_s1[ERR_W-1]}}, err_s1};
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_next = sum_wide[SUM_W-1:0];
		end
		diff_next = {err_s1[ERR_W-1], err_s1} - {prev_err_q[ERR_W-1], prev_err_q};
		turn_next = turn_seen_q || hit_s1;
	end

	always_comb begin
		total = {{(STEER_W+2-16){p_prod_s3[15]}}, p_prod_s3}
		      + {{(STEER_W+2-33){i_prod_s3[32]}}, i_prod_s3}
		      + {{(STEER_W+2-17){d_prod_s3[16]}}, d_prod_s3};
		if (total > 34'sd2147483647) begin
			steer_sat = 32'sh7FFFFFFF;
		end else if (total < -34'sd2147483648) begin
			steer_sat = 32'sh80000000;
		end else begin
			steer_sat = total[STEER_W-1:0];
		end
	end

	// valid bits and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_q         <= 1'b0;
			prev_err_q  <= '0;
			err_sum_q   <= '0;
			turn_seen_q <= 1'b0;
		end else begin
			if (r_s1) v_s1 <= in_valid;
			if (r_s2) v_s2 <= v_s1;
			if (r_s3) v_s3 <= v_s2;
			if (r_q)  v_q  <= v_s3;
			if (v_s1 && r_s2) begin
				prev_err_q  <= err_s1;
				err_sum_q   <= sum_next;
				turn_seen_q <= turn_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && r_s1) begin
			err_s1 <= in_error;
			hit_s1 <= in_turn_hit;
		end
		if (v_s1 && r_s2) begin
			err_s2  <= err_s1;
			sum_s2  <= sum_next;
			diff_s2 <= diff_next;
			turn_s2 <= turn_next;
		end
		if (v_s2 && r_s3) begin
			err_s3    <= err_s2;
			turn_s3   <= turn_s2;
			p_prod_s3 <= $signed({1'b0, gains.p}) * err_s2;
			i_prod_s3 <= $signed({1'b0, gains.i}) * sum_s2;
			d_prod_s3 <= $signed({1'b0, gains.d}) * diff_s2;
		end
		if (v_s3 && r_q) begin
			out_steer <= steer_sat;
			out_error <= err_s3;
			out_turn  <= turn_s3;
		end
	end

	assign out_valid = v_q;
endmodule

@@ hdl/line_position_pid_steering.sv @@
// pipeline: an accepted item is registered in stages s1, s2, s3 and then the output register
// throughput: one item per cycle while result.ready does not stall the pipeline, limited by
//   the error sum and previous error update in stage 2
// reset: arst_n clears the pipeline valids, error sum, previous error and
//   turn flag, and loads the gains with 120, 0 and 8
module line_position_pid_steering (
	input  logic         clk,
	input  logic         arst_n,
	lps_probe_if.sink    probe,
	lps_result_if.source result,
	lps_cfg_if.sink      cfg
);
	import lps_pkg::*;

	gains_t gains_q;
	err_t   line_error;
	logic   turn_hit;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.p <= GAIN_P_RST;
			gains_q.i <= GAIN_I_RST;
			gains_q.d <= GAIN_D_RST;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_GAIN_P: gains_q.p <= cfg.data;
				REG_GAIN_I: gains_q.i <= cfg.data;
				REG_GAIN_D: gains_q.d <= cfg.data;
				default: ;
			endcase
		end
	end

	lps_error u_error (
		.probe_bits (probe.probe_bits),
		.line_error (line_error)
	);

	// probe bits 0 and 1 both black
	assign turn_hit = (probe.probe_bits[1:0] == 2'b00);

	lps_pid u_pid (
		.clk         (clk),
		.arst_n      (arst_n),
		.gains       (gains_q),
		.in_valid    (probe.valid),
		.in_ready    (probe.ready),
		.in_error    (line_error),
		.in_turn_hit (turn_hit),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.out_steer   (result.steer),
		.out_error   (result.line_error),
		.out_turn    (result.turn_latched)
	);
endmodule

@@ hdl/lps_checker.sv @@
module lps_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input lps_pkg::steer_t       out_steer,
	input lps_pkg::err_t         out_error,
	input logic                  out_turn
);
	import lps_pkg::*;

	logic turn_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_seen_q <= 1'b0;
		end else if (out_valid && out_ready && out_turn) begin
			turn_seen_q <= 1'b1;
		end
	end

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	a_error_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(out_error) >= -7'sd50 && $signed(out_error) <= 7'sd50))
		else $error("line error out of range");

	a_turn_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && turn_seen_q) |-> out_turn)
		else $error("turn flag dropped");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_steer)))
		else $error("stalled result changed");
endmodule

bind line_position_pid_steering lps_checker u_lps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_steer (result.steer),
	.out_error (result.line_error),
	.out_turn  (result.turn_latched)
);
